@@ design/i2cms_pkg.sv @@
package i2cms_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_COUNT_WIDTH = 4;
   localparam logic [7:0] ACK_LIMIT_RESET = 8'd200;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   // Word index of each register: the address bit above the byte offset.
   localparam logic CSR_IDX_ACK_LIMIT = 1'b0;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'd0,
      PH_ST0   = 5'd1,
      PH_ST1   = 5'd2,
      PH_ST2   = 5'd3,
      PH_ST3   = 5'd4,
      PH_SP0   = 5'd5,
      PH_SP1   = 5'd6,
      PH_SP2   = 5'd7,
      PH_WB0   = 5'd8,
      PH_WB1   = 5'd9,
      PH_WB2   = 5'd10,
      PH_WREL  = 5'd11,
      PH_WACK  = 5'd12,
      PH_WOK   = 5'd13,
      PH_WFAIL = 5'd14,
      PH_RREL  = 5'd15,
      PH_RB0   = 5'd16,
      PH_RB1   = 5'd17,
      PH_RB2   = 5'd18
   } phase_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [1:0] req_type;
      logic [7:0] tx_byte;
      logic       wait_ack;
      logic       sda_in;
   } req_type_t_type;

   typedef struct packed {
      logic       cmd_valid;
      phase_type  start_phase;
      logic [7:0] tx_byte;
      logic       wait_ack;
      logic       sda_in;
   } entry_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic       ack_ok;
      logic [7:0] rx_byte;
      logic       cmd_rejected;
   } rsp_type;

endpackage

@@ design/i2cms_chan_if.sv @@
interface i2cms_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ design/i2cms_front.sv @@
module i2cms_front (
   i2cms_chan_if.sink   req_chan,
   i2cms_chan_if.source queue_chan
);
   import i2cms_pkg::*;

   entry_type entry;

   // The command code is turned into the first slot of its sequence here, so
   // the sequencer only has to pick it up when it is idle.
   always_comb begin
      entry.cmd_valid = req_chan.data.cmd_valid;
      entry.tx_byte   = req_chan.data.tx_byte;
      entry.wait_ack  = req_chan.data.wait_ack;
      entry.sda_in    = req_chan.data.sda_in;
      unique case (cmd_type'(req_chan.data.req_type))
         CMD_START: begin
            entry.start_phase = PH_ST0;
         end
         CMD_STOP: begin
            entry.start_phase = PH_SP0;
         end
         CMD_WRITE: begin
            entry.start_phase = PH_WB0;
         end
         CMD_READ: begin
            entry.start_phase = PH_RREL;
         end
         default: begin
            entry.start_phase = PH_IDLE;
         end
      endcase
   end

   assign queue_chan.valid = req_chan.valid;
   assign queue_chan.data  = entry;
   assign req_chan.ready   = queue_chan.ready;

endmodule

@@ design/i2cms_queue.sv @@
module i2cms_queue #(
   parameter int DEPTH = i2cms_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   i2cms_chan_if.sink   push_chan,
   i2cms_chan_if.source pop_chan
);
   import i2cms_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_chan.ready = (count_ff != CNT_W'(DEPTH));
   assign pop_chan.valid  = (count_ff != '0);
   assign pop_chan.data   = slot_ff[rd_ptr_ff];
   assign push = push_chan.valid && push_chan.ready;
   assign pop  = pop_chan.valid && pop_chan.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_chan.data;
      end
   end

   // The fill count never rises above the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count above depth");

endmodule

@@ design/i2cms_back.sv @@
module i2cms_back (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   ack_limit,
   i2cms_chan_if.sink   queue_chan,
   i2cms_chan_if.source rsp_chan
);
   import i2cms_pkg::*;

   phase_type phase_ff, phase_in;
   logic [BIT_COUNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] tmo_ff, tmo_in;
   logic ack_wait_ff, ack_wait_in;
   logic scl_drv_ff, scl_drv_in;
   logic sda_drv_ff, sda_drv_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   entry_type entry;
   phase_type slot_phase;
   logic [BIT_COUNT_WIDTH-1:0] bc, bc_inc;
   logic [7:0] sh;
   logic aw;
   logic take;
   logic done, ack;
   logic [7:0] rx;
   logic rej;

   assign entry = queue_chan.data;
   assign queue_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take = queue_chan.valid && queue_chan.ready;

   always_comb begin
      slot_phase = phase_ff;
      bc  = bit_cnt_ff;
      sh  = shift_ff;
      aw  = ack_wait_ff;
      rej = 1'b0;
      // A command while a sequence runs is dropped; an idle command runs its
      // first slot on the same tick.
      if (phase_ff != PH_IDLE) begin
         rej = entry.cmd_valid;
      end else if (entry.cmd_valid) begin
         slot_phase = entry.start_phase;
         bc = '0;
         if (entry.start_phase == PH_WB0) begin
            sh = entry.tx_byte;
            aw = entry.wait_ack;
         end else if (entry.start_phase == PH_RREL) begin
            sh = '0;
         end
      end
      bc_inc = bc + 1'b1;

      phase_in    = slot_phase;
      bit_cnt_in  = bc;
      shift_in    = sh;
      tmo_in      = tmo_ff;
      ack_wait_in = aw;
      scl_drv_in  = scl_drv_ff;
      sda_drv_in  = sda_drv_ff;
      done = 1'b0;
      ack  = 1'b0;
      rx   = '0;

      unique case (slot_phase)
         PH_IDLE: begin
            phase_in = PH_IDLE;
         end
         PH_ST0: begin
            sda_drv_in = 1'b1;
            phase_in = PH_ST1;
         end
         PH_ST1: begin
            scl_drv_in = 1'b1;
            phase_in = PH_ST2;
         end
         PH_ST2: begin
            sda_drv_in = 1'b0;
            phase_in = PH_ST3;
         end
         PH_ST3: begin
            scl_drv_in = 1'b0;
            done = 1'b1;
            phase_in = PH_IDLE;
         end
         PH_SP0: begin
            sda_drv_in = 1'b0;
            phase_in = PH_SP1;
         end
         PH_SP1: begin
            scl_drv_in = 1'b1;
            phase_in = PH_SP2;
         end
         PH_SP2: begin
            sda_drv_in = 1'b1;
            done = 1'b1;
            phase_in = PH_IDLE;
         end
         PH_WB0: begin
            sda_drv_in = sh[7];
            shift_in = {sh[6:0], 1'b0};
            phase_in = PH_WB1;
         end
         PH_WB1: begin
            scl_drv_in = 1'b1;
            phase_in = PH_WB2;
         end
         PH_WB2: begin
            scl_drv_in = 1'b0;
            bit_cnt_in = bc_inc;
            phase_in = (bc_inc >= BIT_COUNT_WIDTH'(BITS_PER_BYTE)) ? PH_WREL : PH_WB0;
         end
         PH_WREL: begin
            sda_drv_in = 1'b1;
            tmo_in = '0;
            phase_in = PH_WACK;
         end
         PH_WACK: begin
            scl_drv_in = 1'b1;
            if (!aw || !entry.sda_in) begin
               phase_in = PH_WOK;
            end else if (tmo_ff >= ack_limit) begin
               phase_in = PH_WFAIL;
            end else begin
               tmo_in = tmo_ff + 1'b1;
            end
         end
         PH_WOK: begin
            scl_drv_in = 1'b0;
            done = 1'b1;
            ack = 1'b1;
            phase_in = PH_IDLE;
         end
         PH_WFAIL: begin
            scl_drv_in = 1'b0;
            done = 1'b1;
            phase_in = PH_IDLE;
         end
         PH_RREL: begin
            sda_drv_in = 1'b1;
            phase_in = PH_RB0;
         end
         PH_RB0: begin
            scl_drv_in = 1'b1;
            phase_in = PH_RB1;
         end
         PH_RB1: begin
            shift_in = {sh[6:0], entry.sda_in};
            phase_in = PH_RB2;
         end
         PH_RB2: begin
            scl_drv_in = 1'b0;
            bit_cnt_in = bc_inc;
            if (bc_inc >= BIT_COUNT_WIDTH'(BITS_PER_BYTE)) begin
               done = 1'b1;
               rx = sh;
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_RB0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      rsp_data_in.scl_out      = scl_drv_in;
      rsp_data_in.sda_out      = sda_drv_in;
      rsp_data_in.busy_res     = (phase_in != PH_IDLE);
      rsp_data_in.done_res     = done;
      rsp_data_in.ack_ok       = ack;
      rsp_data_in.rx_byte      = rx;
      rsp_data_in.cmd_rejected = rej;

      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_cnt_ff   <= '0;
         shift_ff     <= '0;
         tmo_ff       <= '0;
         ack_wait_ff  <= 1'b0;
         scl_drv_ff   <= 1'b1;
         sda_drv_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff    <= phase_in;
            bit_cnt_ff  <= bit_cnt_in;
            shift_ff    <= shift_in;
            tmo_ff      <= tmo_in;
            ack_wait_ff <= ack_wait_in;
            scl_drv_ff  <= scl_drv_in;
            sda_drv_ff  <= sda_drv_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.done_res |-> !rsp_data_ff.busy_res)
      else $error("completing tick still reports busy");

   a_result_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.ack_ok || (rsp_data_ff.rx_byte != '0))
      |-> rsp_data_ff.done_res)
      else $error("ack or read byte reported without done");

   a_idle_pins_hold: assert property (@(posedge clock) disable iff (reset)
      take && (phase_ff == PH_IDLE) && !entry.cmd_valid
      |=> (scl_drv_ff == $past(scl_drv_ff)) && (sda_drv_ff == $past(sda_drv_ff)))
      else $error("pins moved on an idle tick");

endmodule

@@ design/i2c_master_bit_sequencer.sv @@
// I2C master bit sequencer, advanced by one bus timing tick per request.
// Each request on req_chan is one tick: it may carry a command (start, stop,
// write byte, read byte) and always carries the sampled SDA level. For every
// request exactly one result leaves on rsp_chan with the SCL and SDA drive
// levels after that tick, busy and done flags, the write acknowledge status,
// the byte read and a flag for a command that arrived while busy.
// Throughput is one request per clock while rsp_chan accepts results; the
// sequencer updates its pin state once per request. A request passes the
// command queue between the decoder and the sequencer, then the result
// register. When rsp_chan stalls, the result register holds and the queue
// fills; req_chan.ready drops once QUEUE_DEPTH requests are waiting.
// The register ack_timeout_limit lies at byte address 0 of the csr_ port;
// pready is always high and writes belong to idle periods.
// Reset (synchronous) returns the sequencer to idle with SCL and SDA
// released high, empties the queue and sets the timeout limit to 200.
module i2c_master_bit_sequencer #(
   parameter int QUEUE_DEPTH = i2cms_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   i2cms_chan_if.sink                          req_chan,
   i2cms_chan_if.source                        rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [i2cms_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [i2cms_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [i2cms_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import i2cms_pkg::*;

   logic [7:0] ack_limit_ff, ack_limit_in;
   logic csr_write;

   i2cms_chan_if #(.payload_type(entry_type)) front_q ();
   i2cms_chan_if #(.payload_type(entry_type)) q_back ();

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      ack_limit_in = ack_limit_ff;
      if (csr_write && (csr_paddr[2] == CSR_IDX_ACK_LIMIT)) begin
         ack_limit_in = csr_pwdata[7:0];
      end
      if (csr_paddr[2] == CSR_IDX_ACK_LIMIT) begin
         csr_prdata = {{(CSR_DATA_WIDTH - 8){1'b0}}, ack_limit_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_limit_ff <= ACK_LIMIT_RESET;
      end else begin
         ack_limit_ff <= ack_limit_in;
      end
   end

   i2cms_front u_front (
      .req_chan   (req_chan),
      .queue_chan (front_q)
   );

   i2cms_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_chan (front_q),
      .pop_chan  (q_back)
   );

   i2cms_back u_back (
      .clock      (clock),
      .reset      (reset),
      .ack_limit  (ack_limit_ff),
      .queue_chan (q_back),
      .rsp_chan   (rsp_chan)
   );

endmodule

@@ tb/sv/i2c_master_bit_sequencer_checker.sv @@
`timescale 1ns / 100ps

module i2c_master_bit_sequencer_checker
   import i2cms_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  req_type_t_type            req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rsp_type                   rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic                      csr_pready,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output int                        fail_count,
   output int                        waiting
);

   // Local copy of the sequencer state.
   phase_type                  seq_phase;
   logic [BIT_COUNT_WIDTH-1:0] bits_done;
   logic [7:0]                 shifter;
   logic [7:0]                 high_samples;
   logic                       ack_wanted;
   logic                       scl_lvl;
   logic                       sda_lvl;
   logic [7:0]                 ack_limit;

   rsp_type bus_results_due[$];
   int      mismatch_count = 0;

   initial begin
      fail_count = 0;
      waiting = 0;
   end

   task automatic report_mismatch(input string what, input logic [CSR_DATA_WIDTH-1:0] got,
                                  input logic [CSR_DATA_WIDTH-1:0] want);
      // Keep the log short when the design is badly broken.
      if (mismatch_count < 100) begin
         $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [CSR_DATA_WIDTH-1:0] got,
                              input logic [CSR_DATA_WIDTH-1:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   // Advances the bus sequencer by one tick and returns the pin and status result.
   task automatic step_bus(input req_type_t_type tick, output rsp_type res);
      res = '0;
      res.cmd_rejected = (seq_phase != PH_IDLE) && tick.cmd_valid;
      if (seq_phase == PH_IDLE && tick.cmd_valid) begin
         bits_done = '0;
         case (cmd_type'(tick.req_type))
            CMD_START: seq_phase = PH_ST0;
            CMD_STOP:  seq_phase = PH_SP0;
            CMD_WRITE: begin
               shifter = tick.tx_byte;
               ack_wanted = tick.wait_ack;
               seq_phase = PH_WB0;
            end
            default: begin
               shifter = '0;
               seq_phase = PH_RREL;
            end
         endcase
      end
      // The slot of a newly accepted command runs on the tick that carries it.
      case (seq_phase)
         PH_IDLE: ;
         PH_ST0: begin sda_lvl = 1'b1; seq_phase = PH_ST1; end
         PH_ST1: begin scl_lvl = 1'b1; seq_phase = PH_ST2; end
         PH_ST2: begin sda_lvl = 1'b0; seq_phase = PH_ST3; end
         PH_ST3: begin
            scl_lvl = 1'b0;
            res.done_res = 1'b1;
            seq_phase = PH_IDLE;
         end
         PH_SP0: begin sda_lvl = 1'b0; seq_phase = PH_SP1; end
         PH_SP1: begin scl_lvl = 1'b1; seq_phase = PH_SP2; end
         PH_SP2: begin
            sda_lvl = 1'b1;
            res.done_res = 1'b1;
            seq_phase = PH_IDLE;
         end
         PH_WB0: begin
            sda_lvl = shifter[7];
            shifter = {shifter[6:0], 1'b0};
            seq_phase = PH_WB1;
         end
         PH_WB1: begin scl_lvl = 1'b1; seq_phase = PH_WB2; end
         PH_WB2: begin
            scl_lvl = 1'b0;
            bits_done = bits_done + 1'b1;
            seq_phase = (bits_done >= BITS_PER_BYTE) ? PH_WREL : PH_WB0;
         end
         PH_WREL: begin
            sda_lvl = 1'b1;
            high_samples = '0;
            seq_phase = PH_WACK;
         end
         PH_WACK: begin
            scl_lvl = 1'b1;
            if (!ack_wanted || !tick.sda_in) begin
               seq_phase = PH_WOK;
            end else if (high_samples >= ack_limit) begin
               seq_phase = PH_WFAIL;
            end else begin
               high_samples = high_samples + 1'b1;
            end
         end
         PH_WOK, PH_WFAIL: begin
            scl_lvl = 1'b0;
            res.done_res = 1'b1;
            res.ack_ok = (seq_phase == PH_WOK);
            seq_phase = PH_IDLE;
         end
         PH_RREL: begin sda_lvl = 1'b1; seq_phase = PH_RB0; end
         PH_RB0: begin scl_lvl = 1'b1; seq_phase = PH_RB1; end
         PH_RB1: begin
            shifter = {shifter[6:0], tick.sda_in};
            seq_phase = PH_RB2;
         end
         PH_RB2: begin
            scl_lvl = 1'b0;
            bits_done = bits_done + 1'b1;
            if (bits_done >= BITS_PER_BYTE) begin
               res.done_res = 1'b1;
               res.rx_byte = shifter;
               seq_phase = PH_IDLE;
            end else begin
               seq_phase = PH_RB0;
            end
         end
         default: seq_phase = PH_IDLE;
      endcase
      res.scl_out = scl_lvl;
      res.sda_out = sda_lvl;
      res.busy_res = (seq_phase != PH_IDLE);
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         seq_phase = PH_IDLE;
         bits_done = '0;
         shifter = '0;
         high_samples = '0;
         ack_wanted = 1'b0;
         scl_lvl = 1'b1;
         sda_lvl = 1'b1;
         ack_limit = ACK_LIMIT_RESET;
         bus_results_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_ADDR_WIDTH-1:2] == CSR_IDX_ACK_LIMIT) begin
            if (csr_pwrite) begin
               ack_limit = csr_pwdata[7:0];
            end else begin
               check_field("ack_timeout_limit read", csr_prdata, ack_limit);
            end
         end
         if (req_valid && req_ready) begin
            step_bus(req_data, want);
            bus_results_due.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (bus_results_due.size() == 0) begin
               report_mismatch("result with no request waiting", rsp_data, '0);
            end else begin
               want = bus_results_due.pop_front();
               check_field("scl_out", rsp_data.scl_out, want.scl_out);
               check_field("sda_out", rsp_data.sda_out, want.sda_out);
               check_field("busy_res", rsp_data.busy_res, want.busy_res);
               check_field("done_res", rsp_data.done_res, want.done_res);
               check_field("ack_ok", rsp_data.ack_ok, want.ack_ok);
               check_field("rx_byte", rsp_data.rx_byte, want.rx_byte);
               check_field("cmd_rejected", rsp_data.cmd_rejected, want.cmd_rejected);
            end
         end
      end
      waiting <= bus_results_due.size();
      fail_count <= mismatch_count;
   end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import i2cms_pkg::*;

   localparam int QUIET_LIMIT = 200;
   localparam int PHASE_TICKS = 260;

   logic                      clock;
   logic                      reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   int         fail_count;
   int         waiting;
   int         quiet_cycles = 0;
   int         ticks_sent = 0;
   logic [7:0] cur_limit = ACK_LIMIT_RESET;
   bit         req_gaps_on = 1'b0;
   bit         rsp_stalls_on = 1'b0;

   i2cms_chan_if #(.payload_type(req_type_t_type)) req_if ();
   i2cms_chan_if #(.payload_type(rsp_type))        rsp_if ();

   i2c_master_bit_sequencer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   i2c_master_bit_sequencer_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_data    (req_if.data),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_data    (rsp_if.data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .fail_count  (fail_count),
      .waiting     (waiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("i2c_master_bit_sequencer test failed");
         $finish;
      end
   end

   // Result side: a random stall before each result, in stretches with and without stalls.
   initial begin : rsp_side
      int stall;
      int stretch_left;
      stretch_left = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stretch_left == 0) begin
            rsp_stalls_on = $urandom_range(0, 1);
            stretch_left = $urandom_range(20, 80);
         end
         stretch_left--;
         stall = rsp_stalls_on ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   task automatic send_tick(input logic cmd, input cmd_type kind, input logic [7:0] tx_val,
                            input logic ack_req, input logic sda_lvl);
      req_type_t_type tick;
      int gap;
      tick.cmd_valid = cmd;
      tick.req_type = kind;
      tick.tx_byte = tx_val;
      tick.wait_ack = ack_req;
      tick.sda_in = sda_lvl;
      gap = req_gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= tick;
      do @(posedge clock); while (!req_if.ready);
      ticks_sent++;
   endtask

   // A tick inside a running sequence; an occasional command here must be refused.
   task automatic busy_tick(input logic sda_lvl);
      send_tick($urandom_range(0, 7) == 0, cmd_type'($urandom_range(0, 3)), 8'($urandom),
                1'($urandom), sda_lvl);
   endtask

   task automatic idle_tick(input logic sda_lvl);
      send_tick(1'b0, cmd_type'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), sda_lvl);
   endtask

   task automatic csr_access(input logic wr, input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {CSR_IDX_ACK_LIMIT, 2'b00};
      csr_pwdata <= {{(CSR_DATA_WIDTH-8){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Stops requests and waits until every result has come back.
   task automatic drain;
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
   endtask

   task automatic run_sequence;
      cmd_type    kind;
      logic [7:0] tx_val;
      logic       ack_req;
      int         highs;
      int         read_mode;
      kind = cmd_type'($urandom_range(0, 3));
      req_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 19) == 0) begin
         // Broken sequence: cut short, then low SDA ticks until it has surely ended.
         send_tick(1'b1, kind, 8'($urandom), 1'($urandom), 1'($urandom));
         repeat ($urandom_range(0, 10)) busy_tick(1'($urandom));
         repeat (30) idle_tick(1'b0);
         return;
      end
      case (kind)
         CMD_START: begin
            send_tick(1'b1, kind, 8'($urandom), 1'($urandom), 1'($urandom));
            repeat (3) busy_tick(1'($urandom));
         end
         CMD_STOP: begin
            send_tick(1'b1, kind, 8'($urandom), 1'($urandom), 1'($urandom));
            repeat (2) busy_tick(1'($urandom));
         end
         CMD_WRITE: begin
            case ($urandom_range(0, 7))
               0:       tx_val = 8'h00;
               1:       tx_val = 8'hFF;
               default: tx_val = 8'($urandom);
            endcase
            ack_req = ($urandom_range(0, 3) != 0);
            send_tick(1'b1, kind, tx_val, ack_req, 1'($urandom));
            // Remaining bit slots and the SDA release.
            repeat (24) busy_tick(1'($urandom));
            if (!ack_req) begin
               busy_tick(1'($urandom));
            end else if ($urandom_range(0, (cur_limit < 16) ? 1 : 9) == 0) begin
               repeat (int'(cur_limit) + 1) busy_tick(1'b1);
            end else begin
               highs = $urandom_range(0, (cur_limit < 6) ? int'(cur_limit) : 6);
               repeat (highs) busy_tick(1'b1);
               busy_tick(1'b0);
            end
            busy_tick(1'($urandom));
         end
         default: begin
            read_mode = $urandom_range(0, 5);
            send_tick(1'b1, kind, 8'($urandom), 1'($urandom), 1'($urandom));
            repeat (24) begin
               busy_tick((read_mode == 0) ? 1'b1 : (read_mode == 1) ? 1'b0 : 1'($urandom));
            end
         end
      endcase
      repeat ($urandom_range(0, 2)) idle_tick(1'($urandom));
   endtask

   initial begin : stimulus
      logic [7:0] limits[5];
      limits = '{8'd200, 8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254))};
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < 5; p++) begin
         if (p > 0) begin
            drain();
         end
         csr_access(1'b1, limits[p]);
         cur_limit = limits[p];
         csr_access(1'b0, 8'h00);
         if (p == 0) begin
            // Idle ticks: the pins hold and SDA is ignored.
            send_tick(1'b0, CMD_WRITE, 8'hFF, 1'b1, 1'b1);
            send_tick(1'b0, CMD_READ, 8'h00, 1'b0, 1'b0);
            // Start, with a command in the middle and one on its completing tick.
            send_tick(1'b1, CMD_START, 8'h00, 1'b0, 1'b1);
            send_tick(1'b1, CMD_STOP, 8'hFF, 1'b1, 1'b0);
            send_tick(1'b0, CMD_START, 8'h00, 1'b0, 1'b1);
            send_tick(1'b1, CMD_WRITE, 8'hA5, 1'b1, 1'b0);
            send_tick(1'b1, CMD_STOP, 8'h00, 1'b0, 1'b0);
            send_tick(1'b0, CMD_STOP, 8'h00, 1'b0, 1'b1);
            send_tick(1'b1, CMD_READ, 8'h5A, 1'b0, 1'b1);
            send_tick(1'b1, CMD_STOP, 8'hFF, 1'b1, 1'b1);
            repeat (2) idle_tick(1'b1);
            send_tick(1'b1, CMD_STOP, 8'h00, 1'b0, 1'b0);
            repeat (2) busy_tick(1'b0);
         end
         ticks_sent = 0;
         while (ticks_sent < PHASE_TICKS) run_sequence();
      end

      drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("i2c_master_bit_sequencer test passed");
      end else begin
         $display("i2c_master_bit_sequencer test failed");
      end
      $finish;
   end

endmodule
